// ----- design/tds_pkg.sv -----
package tds_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam int TIME_W  = 32;
    localparam int SPEED_W = 14;
    localparam int STEP_W  = 8;
    localparam int CODE_W  = 8;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // ring word: target flag above the deadline
    localparam int WORD_W  = TIME_W + 1;

    localparam logic [CODE_W-1:0] CODE_A = 8'h31;
    localparam logic [CODE_W-1:0] CODE_B = 8'h32;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_A   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_B   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 2'd3;

    localparam logic [TIME_W-1:0]  DELAY_A_RST   = 32'd1400;
    localparam logic [TIME_W-1:0]  DELAY_B_RST   = 32'd8500;
    localparam logic [SPEED_W-1:0] SPEED_MAX_RST = 14'd1000;
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// ----- design/timed_diverter_scheduler_unit.sv -----
// Conveyor diverter timer. Each request (start while busy is low) is one tick: the time
// counter advances, every pending ring entry whose deadline is reached raises the fire flag
// of its diverter, the belt speed ramps (key held) or drops to zero (key released), held
// flags are emitted while the key is held, and a recognized code A or B is queued with its
// deadline. Each request runs from acceptance to the one-cycle o_valid strobe; the ring is
// scanned one entry per cycle through a single registered memory read port and one shared
// 32-bit adder, which also forms the new deadline. busy is high for the whole tick; o_valid
// comes in the cycle busy falls, and a new request may be given in that same cycle. The
// receiver cannot stall: results are shown once and must be taken. Configuration writes
// take effect at once and are meant for idle periods only.
module timed_diverter_scheduler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_key_pressed,
    input  logic                          i_item_valid,
    input  logic [tds_pkg::CODE_W-1:0]    i_item_code,
    input  logic                          i_cfg_we,
    input  logic [tds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tds_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic [tds_pkg::SPEED_W-1:0]   o_belt_speed,
    output logic                          o_fire_a,
    output logic                          o_fire_b
);

    localparam logic [tds_pkg::IDX_W-1:0] LAST_IDX = tds_pkg::IDX_W'(tds_pkg::ENTRIES - 1);

    tds_pkg::t_state r_state, n_state;

    logic [tds_pkg::TIME_W-1:0]  r_delay_a, r_delay_b;
    logic [tds_pkg::SPEED_W-1:0] r_speed_max;
    logic [tds_pkg::STEP_W-1:0]  r_ramp_step;

    logic [tds_pkg::TIME_W-1:0]  r_tick;
    logic [tds_pkg::IDX_W-1:0]   r_slot;
    logic [tds_pkg::IDX_W-1:0]   r_idx;
    logic [tds_pkg::IDX_W-1:0]   r_rd_idx;
    logic                        r_rd_vld;
    logic [tds_pkg::WORD_W-1:0]  r_rd_data;
    logic [tds_pkg::ENTRIES-1:0] r_pending;
    logic [1:0]                  r_fire_pending;
    logic [tds_pkg::SPEED_W-1:0] r_speed;

    logic                        r_key, r_item_valid;
    logic [tds_pkg::CODE_W-1:0]  r_item_code;

    logic                        r_out_vld, r_fire_a, r_fire_b;

    logic [tds_pkg::WORD_W-1:0]  mem [tds_pkg::ENTRIES];

    logic accept, scan_rd, finish;
    logic [tds_pkg::TIME_W-1:0]  add_b;
    logic                        add_cin;
    logic [tds_pkg::TIME_W-1:0]  add_sum;
    logic                        hit;
    logic                        is_a, is_b;
    logic [tds_pkg::SPEED_W:0]   ramp_sum;
    logic [tds_pkg::SPEED_W-1:0] speed_next;

    assign accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tds_pkg::ST_IDLE:   if (start) n_state = tds_pkg::ST_SCAN;
            tds_pkg::ST_SCAN:   if (r_idx == LAST_IDX) n_state = tds_pkg::ST_DRAIN;
            tds_pkg::ST_DRAIN:  n_state = tds_pkg::ST_FINISH;
            tds_pkg::ST_FINISH: n_state = tds_pkg::ST_IDLE;
            default:            n_state = tds_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy    = 1'b1;
        scan_rd = 1'b0;
        finish  = 1'b0;
        case (r_state)
            tds_pkg::ST_IDLE:   busy = 1'b0;
            tds_pkg::ST_SCAN:   scan_rd = 1'b1;
            tds_pkg::ST_DRAIN:  ;
            tds_pkg::ST_FINISH: finish = 1'b1;
            default:            busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tds_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // shared adder: now - deadline while scanning, now + delay when storing
    assign is_a = r_item_code == tds_pkg::CODE_A;
    assign is_b = r_item_code == tds_pkg::CODE_B;

    always_comb begin
        if (r_rd_vld) begin
            add_b   = ~r_rd_data[tds_pkg::TIME_W-1:0];
            add_cin = 1'b1;
        end else begin
            add_b   = is_b ? r_delay_b : r_delay_a;
            add_cin = 1'b0;
        end
    end

    assign add_sum = r_tick + add_b + tds_pkg::TIME_W'(add_cin);
    assign hit     = r_rd_vld && r_pending[r_rd_idx] && !add_sum[tds_pkg::TIME_W-1];

    // belt ramp with clamp
    assign ramp_sum = {1'b0, r_speed} + (tds_pkg::SPEED_W + 1)'(r_ramp_step);

    always_comb begin
        if (!r_key) begin
            speed_next = '0;
        end else if (r_speed < r_speed_max) begin
            if (ramp_sum > {1'b0, r_speed_max}) speed_next = r_speed_max;
            else                                speed_next = ramp_sum[tds_pkg::SPEED_W-1:0];
        end else begin
            speed_next = r_speed_max;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_a   <= tds_pkg::DELAY_A_RST;
            r_delay_b   <= tds_pkg::DELAY_B_RST;
            r_speed_max <= tds_pkg::SPEED_MAX_RST;
            r_ramp_step <= tds_pkg::RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tds_pkg::REG_DELAY_A:   r_delay_a   <= i_cfg_data;
                tds_pkg::REG_DELAY_B:   r_delay_b   <= i_cfg_data;
                tds_pkg::REG_SPEED_MAX: r_speed_max <= i_cfg_data[tds_pkg::SPEED_W-1:0];
                tds_pkg::REG_RAMP_STEP: r_ramp_step <= i_cfg_data[tds_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key        <= i_key_pressed;
            r_item_valid <= i_item_valid;
            r_item_code  <= i_item_code;
        end
    end

    // ring memory, one registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_idx];
        if (finish && r_item_valid && (is_a || is_b))
            mem[r_slot] <= {is_b, add_sum};
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_slot         <= '0;
            r_idx          <= '0;
            r_rd_vld       <= 1'b0;
            r_pending      <= '0;
            r_fire_pending <= '0;
            r_speed        <= '0;
            r_out_vld      <= 1'b0;
            r_fire_a       <= 1'b0;
            r_fire_b       <= 1'b0;
        end else begin
            r_rd_vld  <= scan_rd;
            r_out_vld <= finish;

            if (accept) begin
                r_tick <= r_tick + 1'b1;
                r_idx  <= '0;
            end else if (scan_rd) begin
                r_idx  <= r_idx + 1'b1;
            end

            if (hit) begin
                r_pending[r_rd_idx] <= 1'b0;
                if (r_rd_data[tds_pkg::TIME_W]) r_fire_pending[1] <= 1'b1;
                else                            r_fire_pending[0] <= 1'b1;
            end

            if (finish) begin
                r_speed <= speed_next;
                if (r_key) begin
                    r_fire_a       <= r_fire_pending[0];
                    r_fire_b       <= r_fire_pending[1];
                    r_fire_pending <= '0;
                end else begin
                    r_fire_a <= 1'b0;
                    r_fire_b <= 1'b0;
                end
                if (r_item_valid) begin
                    r_pending[r_slot] <= is_a || is_b;
                    if (r_slot == LAST_IDX) r_slot <= '0;
                    else                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_belt_speed = r_speed;
    assign o_fire_a     = r_fire_a;
    assign o_fire_b     = r_fire_b;

    // result strobe only follows the finishing step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == tds_pkg::ST_FINISH))
        else $error("result strobe without finishing step");

    // a diverter pulse needs the run key of that tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_fire_a || o_fire_b)) |-> r_key)
        else $error("diverter pulse without key held");

    // an accepted request starts the scan
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && r_idx == '0 && r_state == tds_pkg::ST_SCAN))
        else $error("request not followed by scan");

    // compare stage only runs inside a tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == tds_pkg::ST_SCAN || r_state == tds_pkg::ST_DRAIN))
        else $error("ring compare outside scan");

endmodule
